### rtl/imf_pkg.sv
// Shared types and constants for the mask or median image filter.
`timescale 1ns / 1ps

package imf_pkg;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int STAT_W     = 2;
    localparam int IDX_W      = 6;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int MSK_W      = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_AW     = 5;

    typedef logic signed [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic             kind;
        t_pix             pixel;
        logic [IDX_W-1:0] coef_index;
        t_pix             coef_value;
    } t_in_item;

    typedef struct packed {
        t_pix              value;
        logic [ROW_W-1:0]  center_row;
        logic [COL_W-1:0]  center_col;
        logic [STAT_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic take_next;
        logic take_load;
        logic load_tag;
        logic tag_val;
    } t_cell_ctrl;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_EVEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_BIG  = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_COEF  = 1'b1;

    localparam logic [2:0] REG_IMG_W  = 3'd0;
    localparam logic [2:0] REG_IMG_H  = 3'd1;
    localparam logic [2:0] REG_MSK_W  = 3'd2;
    localparam logic [2:0] REG_MSK_H  = 3'd3;
    localparam logic [2:0] REG_MEDIAN = 3'd4;

endpackage

### rtl/image_mask_or_median_filter_unit.sv
// Top level of the streaming mask or median image filter with its line store.
// A coefficient load is written while idle; a pixel without a full window passes through the
// modulo, line load and shift states and gives no result, and a pixel with a bad mask goes to emit.
// A full window gives its result after one pass of the cell ring and a drain in median mode,
// and in mean mode after the divider as well.
// One item is in work at a time; a finished result waits in the output register meanwhile.
// Reset is synchronous and active low: registers return to defaults, counters, window cells
// and coefficient valid bits clear; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module image_mask_or_median_filter_unit #(
    parameter int MAX_MASK  = 7,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  imf_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output imf_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [imf_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import imf_pkg::*;

    localparam int NW     = MAX_MASK * MAX_MASK;
    localparam int LR     = (MAX_MASK > 1) ? MAX_MASK - 1 : 1;
    localparam int LRW    = (LR > 1) ? $clog2(LR) : 1;
    localparam int RK     = ROW_W + LRW + 1;
    localparam int RECIP  = ((1 << RK) + LR - 1) / LR;
    localparam int LDEPTH = LR * MAX_WIDTH;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int CAW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int KW     = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
    localparam int SW     = $clog2(NW + 1);
    localparam int PROD_W = 2 * PIX_W;
    localparam int ACC_W  = PROD_W + SW;
    localparam int SUM_W  = PIX_W + SW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_MOD   = 8'b00000010,
        S_LOAD  = 8'b00000100,
        S_SHIFT = 8'b00001000,
        S_ROT   = 8'b00010000,
        S_DRAIN = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_EMIT  = 8'b10000000
    } t_state;

    // Configuration registers.
    logic [IW_W-1:0]  r_img_w;
    logic [IH_W-1:0]  r_img_h;
    logic [MSK_W-1:0] r_msk_w;
    logic [MSK_W-1:0] r_msk_h;
    logic             r_median;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= IW_W'(1024);
            r_img_h  <= IH_W'(1024);
            r_msk_w  <= MSK_W'(3);
            r_msk_h  <= MSK_W'(3);
            r_median <= 1'b0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_IMG_W:  r_img_w  <= pwdata[IW_W-1:0];
                REG_IMG_H:  r_img_h  <= pwdata[IH_W-1:0];
                REG_MSK_W:  r_msk_w  <= pwdata[MSK_W-1:0];
                REG_MSK_H:  r_msk_h  <= pwdata[MSK_W-1:0];
                REG_MEDIAN: r_median <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_IMG_W:  prdata = 32'(r_img_w);
            REG_IMG_H:  prdata = 32'(r_img_h);
            REG_MSK_W:  prdata = 32'(r_msk_w);
            REG_MSK_H:  prdata = 32'(r_msk_h);
            REG_MEDIAN: prdata = 32'(r_median);
            default:    prdata = '0;
        endcase
    end

    // Control and work registers.
    t_state           r_state;
    t_state           n_state;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col_cnt;
    t_pix             r_px;
    logic [ROW_W-1:0] r_r;
    logic [COL_W-1:0] r_c;
    logic             r_full;
    logic [ROW_W-1:0] r_crow;
    logic [COL_W-1:0] r_ccol;
    logic [STAT_W-1:0] r_stat;
    t_pix             r_val;
    logic [LRW-1:0]   r_rmod;
    logic [KW-1:0]    r_ln;
    logic             r_rd_pend;
    logic [KW-1:0]    r_rd_n;
    logic             r_rd_use;
    t_pix             r_col [MAX_MASK];
    logic [SW-1:0]    r_step;
    logic [KW-1:0]    r_kn;
    logic [KW-1:0]    r_km;
    logic [1:0]       r_dcnt;
    logic             r_out_valid;
    t_out_item        r_out_data;

    // Input decode and counter arithmetic.
    logic [IW_W-1:0]   w_eff;
    logic [IH_W-1:0]   h_eff;
    logic [COL_W-1:0]  c_cl;
    logic [ROW_W-1:0]  r_cl;
    logic [STAT_W-1:0] stat_in;
    logic              full_in;
    logic [IW_W-1:0]   c_inc;
    logic [IH_W-1:0]   r_inc;
    logic [COL_W-1:0]  col_nxt;
    logic [ROW_W-1:0]  row_nxt;
    logic              in_acc;
    logic              px_acc;
    logic              coef_acc;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = IW_W'(1);
        end else if (int'(r_img_w) > MAX_WIDTH) begin
            w_eff = IW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = IH_W'(1);
        end else if (int'(r_img_h) > MAX_HEIGHT) begin
            h_eff = IH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_img_h;
        end
        c_cl = ({1'b0, r_col_cnt} >= w_eff) ? COL_W'(w_eff - 1'b1) : r_col_cnt;
        r_cl = ({1'b0, r_row} >= h_eff) ? ROW_W'(h_eff - 1'b1) : r_row;
        if (!r_msk_w[0] || !r_msk_h[0]) begin
            stat_in = ST_EVEN;
        end else if ({8'b0, r_msk_w} > w_eff || {10'b0, r_msk_h} > h_eff
                     || int'(r_msk_w) > MAX_MASK || int'(r_msk_h) > MAX_MASK) begin
            stat_in = ST_BIG;
        end else begin
            stat_in = ST_OK;
        end
        full_in = (int'(r_cl) + 1 >= int'(r_msk_h)) && (int'(c_cl) + 1 >= int'(r_msk_w));
        c_inc = {1'b0, c_cl} + 1'b1;
        r_inc = {1'b0, r_cl} + 1'b1;
        if (c_inc >= w_eff) begin
            col_nxt = '0;
            row_nxt = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_nxt = c_inc[COL_W-1:0];
            row_nxt = r_cl;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign px_acc     = in_acc && (i_in_data.kind == KIND_PIXEL);
    assign coef_acc   = in_acc && (i_in_data.kind == KIND_COEF);

    // Row index modulo the line count by reciprocal multiplication.
    logic [ROW_W+RK-1:0] mod_prod;
    logic [ROW_W-1:0]    mod_quo;
    logic [ROW_W-1:0]    mod_rem;

    always_comb begin
        mod_prod = (ROW_W+RK)'(r_cl) * (ROW_W+RK)'(RECIP);
        mod_quo  = ROW_W'(mod_prod >> RK);
        mod_rem  = r_cl - ROW_W'(int'(mod_quo) * LR);
    end

    // Line store.
    logic           l_we;
    logic [LAW-1:0] l_addr;
    t_pix           r_line [LDEPTH];
    t_pix           r_lq;
    int             src_mod;
    logic           ld_last;
    logic           ld_use;

    always_comb begin
        ld_last = (int'(r_ln) + 1 >= int'(r_msk_h));
        src_mod = int'(r_rmod) + LR - (int'(r_msk_h) - 1 - int'(r_ln));
        if (src_mod >= LR) begin
            src_mod = src_mod - LR;
        end
        ld_use = (int'(r_r) + int'(r_ln) + 1 >= int'(r_msk_h));
        l_we   = (r_state == S_LOAD) && ld_last && (int'(r_msk_h) > 1);
        if (ld_last) begin
            l_addr = LAW'(int'(r_rmod) * MAX_WIDTH + int'(r_c));
        end else begin
            l_addr = LAW'(src_mod * MAX_WIDTH + int'(r_c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_line[l_addr] <= r_px;
        end
        r_lq <= r_line[l_addr];
    end

    // Window: a ring of cells.
    t_pix       w_val [NW];
    logic       w_tag [NW];
    logic [NW-1:0] w_lt;
    logic [NW-1:0] w_eq;
    t_cell_ctrl w_ctrl [NW];
    logic       rot;
    logic       shift;

    assign rot   = (r_state == S_ROT);
    assign shift = (r_state == S_SHIFT);

    for (genvar p = 0; p < NW; p++) begin : g_cell
        localparam int GN = p / MAX_MASK;
        localparam int GM = p % MAX_MASK;
        localparam int GX = (p + 1) % NW;

        always_comb begin
            w_ctrl[p].take_next = rot || (shift && GN < int'(r_msk_h)
                                          && GM + 1 < int'(r_msk_w));
            w_ctrl[p].take_load = shift && GN < int'(r_msk_h) && GM + 1 == int'(r_msk_w);
            w_ctrl[p].load_tag  = shift;
            w_ctrl[p].tag_val   = GN < int'(r_msk_h) && GM < int'(r_msk_w);
        end

        imf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[p]),
            .i_next_val (w_val[GX]),
            .i_next_tag (w_tag[GX]),
            .i_load_val (r_col[GN]),
            .i_cand     (w_val[0]),
            .o_val      (w_val[p]),
            .o_tag      (w_tag[p]),
            .o_lt       (w_lt[p]),
            .o_eq       (w_eq[p])
        );
    end

    // Coefficient store.
    t_pix           r_coef [NW];
    logic [NW-1:0]  r_cvld;
    logic [CAW-1:0] c_addr;
    logic           k_act;
    t_pix           r_cf_q;
    logic           r_cfv_q;

    assign k_act  = (int'(r_kn) < int'(r_msk_h)) && (int'(r_km) < int'(r_msk_w));
    assign c_addr = k_act ? CAW'(int'(r_kn) * int'(r_msk_w) + int'(r_km)) : '0;

    always_ff @(posedge i_clk) begin
        if (coef_acc && int'(i_in_data.coef_index) < NW) begin
            r_coef[CAW'(i_in_data.coef_index)] <= i_in_data.coef_value;
        end
        r_cf_q <= r_coef[c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld  <= '0;
            r_cfv_q <= 1'b0;
        end else begin
            if (coef_acc && int'(i_in_data.coef_index) < NW) begin
                r_cvld[CAW'(i_in_data.coef_index)] <= 1'b1;
            end
            r_cfv_q <= r_cvld[c_addr];
        end
    end

    // Weighted sum and median rank pipelines.
    t_pix                      r_p1_win;
    logic                      r_p1_act;
    logic                      r_p1_vld;
    logic signed [PROD_W-1:0]  r_p2_prod;
    t_pix                      r_p2_cf;
    logic                      r_p2_vld;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SUM_W-1:0]   r_sum;
    t_pix                      cf_use;
    logic [NW-1:0]             r_lt;
    logic [NW-1:0]             r_eq;
    t_pix                      r_cand;
    logic                      r_cact;
    t_pix                      r_med;
    logic [SW:0]               less_cnt;
    logic [SW:0]               eq_cnt;
    logic [SW:0]               rank;
    logic                      med_hit;

    assign cf_use = r_cfv_q ? r_cf_q : '0;

    always_comb begin
        less_cnt = (SW+1)'($countones(r_lt));
        eq_cnt   = (SW+1)'($countones(r_eq));
        rank     = (SW+1)'((int'(r_msk_w) * int'(r_msk_h)) >> 1);
        med_hit  = r_cact && (less_cnt <= rank) && (rank < less_cnt + eq_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_cact   <= 1'b0;
        end else begin
            r_p1_vld <= rot;
            r_p2_vld <= r_p1_vld && r_p1_act;
            r_cact   <= rot && w_tag[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_win  <= w_val[0];
        r_p1_act  <= k_act;
        r_p2_prod <= r_p1_win * cf_use;
        r_p2_cf   <= cf_use;
        r_lt      <= w_lt;
        r_eq      <= w_eq;
        r_cand    <= w_val[0];
        if (shift) begin
            r_acc <= '0;
            r_sum <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_p2_prod);
            r_sum <= r_sum + SUM_W'(r_p2_cf);
        end
        if (med_hit) begin
            r_med <= r_cand;
        end
    end

    // Normalizing division.
    logic             div_start;
    logic             div_done;
    logic [ACC_W-1:0] div_quot;
    logic [ACC_W-1:0] acc_mag;
    logic [SUM_W-1:0] sum_mag;
    logic [SUM_W-1:0] div_dvs;
    logic             acc_neg;
    t_pix             sat_val;

    always_comb begin
        acc_neg = r_acc[ACC_W-1];
        acc_mag = acc_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        div_dvs = (sum_mag == '0) ? SUM_W'(1) : sum_mag;
        if (acc_neg) begin
            sat_val = (div_quot > ACC_W'(32768)) ? t_pix'(16'sh8000)
                                                 : t_pix'(-div_quot[PIX_W-1:0]);
        end else begin
            sat_val = (div_quot > ACC_W'(32767)) ? t_pix'(16'sh7fff)
                                                 : t_pix'(div_quot[PIX_W-1:0]);
        end
    end

    assign div_start = (r_state == S_DRAIN) && (r_dcnt == 2'd2) && !r_median;

    imf_div #(
        .DW (ACC_W),
        .VW (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_mag),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequencer.
    logic emit_ok;

    assign emit_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (px_acc) begin
                    n_state = (stat_in != ST_OK) ? S_EMIT : S_MOD;
                end
            end
            S_MOD: n_state = S_LOAD;
            S_LOAD: begin
                if (ld_last) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: n_state = r_full ? S_ROT : S_IDLE;
            S_ROT: begin
                if (int'(r_step) == NW - 1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_dcnt == 2'd2) begin
                    n_state = r_median ? S_EMIT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (px_acc) begin
                r_row     <= row_nxt;
                r_col_cnt <= col_nxt;
            end
            r_rd_pend <= (r_state == S_LOAD) && !ld_last;
            if (r_state == S_EMIT && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (px_acc) begin
            r_px   <= i_in_data.pixel;
            r_r    <= r_cl;
            r_c    <= c_cl;
            r_full <= full_in;
            r_stat <= stat_in;
            r_val  <= '0;
            r_rmod <= LRW'(mod_rem);
            if (stat_in != ST_OK) begin
                r_crow <= r_cl;
                r_ccol <= c_cl;
            end else begin
                r_crow <= ROW_W'(r_cl - ROW_W'(r_msk_h >> 1));
                r_ccol <= COL_W'(c_cl - COL_W'(r_msk_w >> 1));
            end
        end
        if (r_state == S_MOD) begin
            r_ln <= '0;
        end
        if (r_state == S_LOAD) begin
            r_rd_n   <= r_ln;
            r_rd_use <= ld_use;
            if (ld_last) begin
                r_col[r_ln] <= r_px;
            end else begin
                r_ln <= r_ln + 1'b1;
            end
        end
        if (r_rd_pend) begin
            r_col[r_rd_n] <= r_rd_use ? r_lq : '0;
        end
        if (shift) begin
            r_step <= '0;
            r_kn   <= '0;
            r_km   <= '0;
        end
        if (rot) begin
            r_step <= r_step + 1'b1;
            if (int'(r_km) == MAX_MASK - 1) begin
                r_km <= '0;
                r_kn <= r_kn + 1'b1;
            end else begin
                r_km <= r_km + 1'b1;
            end
            r_dcnt <= '0;
        end
        if (r_state == S_DRAIN) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == 2'd2 && r_median) begin
                r_val <= r_med;
            end
        end
        if (r_state == S_DIV && div_done) begin
            r_val <= sat_val;
        end
        if (r_state == S_EMIT && emit_ok) begin
            r_out_data.value      <= r_val;
            r_out_data.center_row <= r_crow;
            r_out_data.center_col <= r_ccol;
            r_out_data.status     <= r_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (int'(r_step) < NW))
        else $error("Ring step ran past the window size.");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_coef_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        coef_acc |=> (r_state == S_IDLE))
        else $error("A coefficient load left the idle state.");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
        else $error("Result dropped while the output register was full.");
`endif

endmodule

### rtl/imf_cell.sv
// One window cell: holds a pixel and a mask tag, and hands them to its neighbor.
`timescale 1ns / 1ps

module imf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imf_pkg::t_cell_ctrl i_ctrl,
    input  imf_pkg::t_pix      i_next_val,
    input  logic               i_next_tag,
    input  imf_pkg::t_pix      i_load_val,
    input  imf_pkg::t_pix      i_cand,
    output imf_pkg::t_pix      o_val,
    output logic               o_tag,
    output logic               o_lt,
    output logic               o_eq
);
    import imf_pkg::*;

    t_pix r_val;
    logic r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_tag <= 1'b0;
        end else begin
            if (i_ctrl.take_next) begin
                r_val <= i_next_val;
            end else if (i_ctrl.take_load) begin
                r_val <= i_load_val;
            end
            if (i_ctrl.load_tag) begin
                r_tag <= i_ctrl.tag_val;
            end else if (i_ctrl.take_next) begin
                r_tag <= i_next_tag;
            end
        end
    end

    assign o_val = r_val;
    assign o_tag = r_tag;
    assign o_lt  = r_tag && (r_val < i_cand);
    assign o_eq  = r_tag && (r_val == i_cand);

endmodule

### rtl/imf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module imf_div #(
    parameter int DW = 38,
    parameter int VW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      n_trial;
    logic             n_bit;

    always_comb begin
        n_trial = {r_rem, r_quo[DW-1]};
        n_bit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_bit ? VW'(n_trial - {1'b0, r_dvs}) : VW'(n_trial);
            r_quo <= {r_quo[DW-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
